FILE: hw/rtl/dlps_pkg.sv
`timescale 1ns / 1ps

package dlps_pkg;

  // Fixed-point format of the read taps and of the blend weight.
  localparam int FRAC_BITS = 12;
  localparam int STEP_W    = 16;
  localparam int WEIGHT_W  = 13;
  localparam int DIST_W    = 7;

  localparam logic [WEIGHT_W-1:0] ONE_Q12 = WEIGHT_W'(4096);

  // Crossfade span in samples behind the write pointer.
  localparam logic [DIST_W-1:0] NEAR_SPAN = DIST_W'(80);

  // Pitch step limits, 0.5 to 8.0 in Q4.12, and its value after reset.
  localparam logic [STEP_W-1:0] STEP_MIN   = STEP_W'(2048);
  localparam logic [STEP_W-1:0] STEP_MAX   = STEP_W'(32768);
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(4096);

  // floor(d * 4096 / 80) = floor(d * 256 / 5), done as d * 52429 >> 10.
  // Exact for every distance up to the crossfade span.
  localparam int RECIP_W = 16;
  localparam logic [RECIP_W-1:0] NEAR_RECIP = RECIP_W'(52429);

  // Per-tap facts worked out when the sample is accepted.
  typedef struct packed {
    logic              fwd;   // tap reads the slot written by this sample
    logic              live;  // slot has been written since reset
    logic              near;  // tap is within the crossfade span
    logic [DIST_W-1:0] lag;   // distance behind the write pointer
  } tap_flags_t;

  typedef struct packed {
    tap_flags_t one;
    tap_flags_t two;
  } tap_info_t;

  // Status of the blend pipeline, seen by the top level.
  typedef struct packed {
    logic                busy;    // first stage holds an item
    logic [WEIGHT_W-1:0] weight;  // running blend weight
  } blend_status_t;

  // Crossfade weight for a tap at distance d behind the write pointer.
  function automatic logic [WEIGHT_W-1:0] near_weight(input logic [DIST_W-1:0] d);
    logic [DIST_W+RECIP_W-1:0] prod;
    prod = {{RECIP_W{1'b0}}, d} * {{DIST_W{1'b0}}, NEAR_RECIP};
    return prod[10 +: WEIGHT_W];
  endfunction

endpackage

FILE: hw/rtl/dlps_store.sv
`timescale 1ns / 1ps

module dlps_store
  import dlps_pkg::*;
#(
  parameter int DEPTH = 4096,
  parameter int W     = 24,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd1_addr,
  input  logic [AW-1:0] rd2_addr,
  output logic [W-1:0]  rd1_data,
  output logic [W-1:0]  rd2_data
);

  logic [W-1:0] mem [DEPTH];

  // One write port and two registered read ports; a read at the written
  // address returns the old contents.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd1_data <= mem[rd1_addr];
      rd2_data <= mem[rd2_addr];
    end
  end

endmodule

FILE: hw/rtl/dlps_addr.sv
`timescale 1ns / 1ps

module dlps_addr
  import dlps_pkg::*;
#(
  parameter int DEPTH = 4096,
  parameter int W     = 24,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [W-1:0]      sample,
  input  logic [STEP_W-1:0] step,
  output logic [AW-1:0]     wr_addr,
  output logic [AW-1:0]     rd1_addr,
  output logic [AW-1:0]     rd2_addr,
  output tap_info_t         info,
  output logic [W-1:0]      sample_q
);

  localparam int TW = AW + FRAC_BITS;
  localparam logic [TW:0]   TapMod   = (TW+1)'(DEPTH * 4096);
  localparam logic [TW-1:0] TapTwoRst = TW'((DEPTH / 2) * 4096);
  localparam logic [AW-1:0] LastIdx  = AW'(DEPTH - 1);
  localparam logic [AW:0]   DepthExt = (AW+1)'(DEPTH);

  logic [AW-1:0] wp;
  logic          full;
  logic [TW-1:0] tap_one;
  logic [TW-1:0] tap_two;

  logic [AW-1:0] wp_next;
  logic [TW-1:0] tap_one_next;
  logic [TW-1:0] tap_two_next;
  tap_info_t     info_next;

  // Integer parts of the taps select the read slots.
  assign wr_addr  = wp;
  assign rd1_addr = tap_one[FRAC_BITS +: AW];
  assign rd2_addr = tap_two[FRAC_BITS +: AW];

  // Advance a tap by the step, wrapping once at the store length.
  function automatic logic [TW-1:0] tap_advance(input logic [TW-1:0] tap,
                                                input logic [STEP_W-1:0] stp);
    logic [TW:0] sum;
    sum = {1'b0, tap} + (TW+1)'(stp);
    if (sum >= TapMod) begin
      sum = sum - TapMod;
    end
    return sum[TW-1:0];
  endfunction

  // Facts about one tap relative to the write pointer.
  function automatic tap_flags_t tap_flags(input logic [AW-1:0] idx,
                                           input logic [AW-1:0] wpt,
                                           input logic          filled);
    tap_flags_t  f;
    logic [AW:0] diff;
    diff = {1'b0, wpt} - {1'b0, idx};
    if (diff[AW]) begin
      diff = diff + DepthExt;
    end
    f.fwd  = (idx == wpt);
    f.live = filled || (idx < wpt);
    f.near = (diff[AW-1:0] <= AW'(NEAR_SPAN));
    f.lag  = diff[DIST_W-1:0];
    return f;
  endfunction

  always_comb begin
    wp_next      = (wp == LastIdx) ? '0 : wp + AW'(1);
    tap_one_next = tap_advance(tap_one, step);
    tap_two_next = tap_advance(tap_two, step);
    info_next.one = tap_flags(rd1_addr, wp, full);
    info_next.two = tap_flags(rd2_addr, wp, full);
  end

  // Pointer and tap state moves on every accepted sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      full    <= 1'b0;
      tap_one <= '0;
      tap_two <= TapTwoRst;
    end else if (accept) begin
      wp      <= wp_next;
      full    <= full || (wp == LastIdx);
      tap_one <= tap_one_next;
      tap_two <= tap_two_next;
    end
  end

  // Tap facts and the sample itself line up with the read data.
  always_ff @(posedge clk) begin
    if (accept) begin
      info     <= info_next;
      sample_q <= sample;
    end
  end

endmodule

FILE: hw/rtl/dlps_blend.sv
`timescale 1ns / 1ps

module dlps_blend
  import dlps_pkg::*;
#(
  parameter int W = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  output logic          ready,
  input  tap_info_t     info,
  input  logic [W-1:0]  sample_q,
  input  logic [W-1:0]  rd1_data,
  input  logic [W-1:0]  rd2_data,
  output logic [W-1:0]  sample_out,
  output logic          out_valid,
  input  logic          out_stall,
  output blend_status_t status
);

  localparam int PW = W + WEIGHT_W + 1;

  // Stage valid flags: 1 read data, 2 taps and weight, 3 products.
  logic v1, v2, v3;
  logic r2, r3, r4;

  logic [WEIGHT_W-1:0] weight;
  logic [WEIGHT_W-1:0] weight_next;
  logic signed [W-1:0] s1_next, s2_next;
  logic signed [W-1:0] s1_q, s2_q;
  logic [WEIGHT_W-1:0] w_q;
  logic signed [PW-1:0] p1_q, p2_q;
  logic signed [WEIGHT_W:0] w1_s, w2_s;
  logic [PW:0] acc;

  // Each stage moves on when the one after it has room.
  assign r4    = !out_valid || !out_stall;
  assign r3    = !v3 || r4;
  assign r2    = !v2 || r3;
  assign ready = !v1 || r2;

  assign status.busy   = v1;
  assign status.weight = weight;

  // Tap samples: the new sample when forwarded, zero for unwritten slots.
  always_comb begin
    priority if (info.one.fwd) begin
      s1_next = $signed(sample_q);
    end else if (info.one.live) begin
      s1_next = $signed(rd1_data);
    end else begin
      s1_next = '0;
    end
    priority if (info.two.fwd) begin
      s2_next = $signed(sample_q);
    end else if (info.two.live) begin
      s2_next = $signed(rd2_data);
    end else begin
      s2_next = '0;
    end
  end

  // Weight update: tap two takes precedence when both taps are near.
  always_comb begin
    priority if (info.two.near) begin
      weight_next = ONE_Q12 - near_weight(info.two.lag);
    end else if (info.one.near) begin
      weight_next = near_weight(info.one.lag);
    end else begin
      weight_next = weight;
    end
  end

  assign w1_s = $signed({1'b0, w_q});
  assign w2_s = $signed({1'b0, ONE_Q12 - w_q});
  assign acc  = {p1_q[PW-1], p1_q} + {p2_q[PW-1], p2_q};

  // Control flags and the running weight.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
      weight    <= '0;
    end else begin
      if (ready) begin
        v1 <= accept;
      end
      if (r2) begin
        v2 <= v1;
      end
      if (r3) begin
        v3 <= v2;
      end
      if (r4) begin
        out_valid <= v3;
      end
      if (v1 && r2) begin
        weight <= weight_next;
      end
    end
  end

  // Datapath: select and weigh, multiply, then sum and floor-shift.
  always_ff @(posedge clk) begin
    if (v1 && r2) begin
      s1_q <= s1_next;
      s2_q <= s2_next;
      w_q  <= weight_next;
    end
    if (v2 && r3) begin
      p1_q <= s1_q * w1_s;
      p2_q <= s2_q * w2_s;
    end
    if (v3 && r4) begin
      sample_out <= acc[FRAC_BITS +: W];
    end
  end

endmodule

FILE: hw/rtl/delay_line_pitch_shifter_top.sv
`timescale 1ns / 1ps
// Channel   Signals                          Request moves
// input     in_valid, in_stall, sample_in    one audio sample
// output    out_valid, out_stall, sample_out one pitch-shifted sample
// config    cfg_valid, cfg_ready, pitch_step one pitch step write
//
// One sample is accepted per cycle while in_stall is low; each result passes
// through the store read, the weight stage, the multiplier and the sum, in that order.
// Synchronous reset returns pointers, taps, weight and step to their start
// values; the store is not swept, since a fill flag makes slots not yet
// written read as zero.
// Stalls travel back through a combinational ready chain, so samples are still
// taken while any pipeline stage has room behind a waiting result.

module delay_line_pitch_shifter_top
  import dlps_pkg::*;
#(
  parameter int BUFFER_DEPTH = 4096,
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [SAMPLE_WIDTH-1:0] sample_in,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [SAMPLE_WIDTH-1:0] sample_out,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [STEP_W-1:0]       pitch_step
);

  localparam int AW = $clog2(BUFFER_DEPTH);

  logic                    accept;
  logic                    ready;
  logic [STEP_W-1:0]       step;
  logic [AW-1:0]           wr_addr;
  logic [AW-1:0]           rd1_addr;
  logic [AW-1:0]           rd2_addr;
  logic [SAMPLE_WIDTH-1:0] rd1_data;
  logic [SAMPLE_WIDTH-1:0] rd2_data;
  logic [SAMPLE_WIDTH-1:0] sample_q;
  tap_info_t               info;
  blend_status_t           status;

  assign in_stall  = !ready;
  assign accept    = in_valid && ready;
  assign cfg_ready = 1'b1;

  // Pitch step register, saturated to its range on every write.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (pitch_step < STEP_MIN) begin
        step <= STEP_MIN;
      end else if (pitch_step > STEP_MAX) begin
        step <= STEP_MAX;
      end else begin
        step <= pitch_step;
      end
    end
  end

  dlps_addr #(
    .DEPTH (BUFFER_DEPTH),
    .W     (SAMPLE_WIDTH),
    .AW    (AW)
  ) u_addr (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .sample   (sample_in),
    .step     (step),
    .wr_addr  (wr_addr),
    .rd1_addr (rd1_addr),
    .rd2_addr (rd2_addr),
    .info     (info),
    .sample_q (sample_q)
  );

  dlps_store #(
    .DEPTH (BUFFER_DEPTH),
    .W     (SAMPLE_WIDTH),
    .AW    (AW)
  ) u_store (
    .clk      (clk),
    .wr_en    (accept),
    .wr_addr  (wr_addr),
    .wr_data  (sample_in),
    .rd_en    (accept),
    .rd1_addr (rd1_addr),
    .rd2_addr (rd2_addr),
    .rd1_data (rd1_data),
    .rd2_data (rd2_data)
  );

  dlps_blend #(
    .W (SAMPLE_WIDTH)
  ) u_blend (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .ready      (ready),
    .info       (info),
    .sample_q   (sample_q),
    .rd1_data   (rd1_data),
    .rd2_data   (rd2_data),
    .sample_out (sample_out),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status)
  );

  // The input is only held off while the first stage is occupied.
  a_stall_busy : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> status.busy)
    else $error("input stalled with an empty first stage");

  // The blend weight never goes above one.
  a_weight_range : assert property (@(posedge clk) disable iff (rst)
    status.weight <= ONE_Q12)
    else $error("blend weight out of range");

  // The pitch step always stays inside its saturation limits.
  a_step_range : assert property (@(posedge clk) disable iff (rst)
    (step >= STEP_MIN) && (step <= STEP_MAX))
    else $error("pitch step out of range");

  // An accepted sample always moves the write pointer on by one slot.
  a_wp_moves : assert property (@(posedge clk) disable iff (rst)
    accept |=> (wr_addr != $past(wr_addr)))
    else $error("write pointer did not advance");

endmodule
